// ===== hw/rtl/kwsig_pkg.sv =====
// shared constants, keyword table and types for the keyword signature classifier
package kwsig_pkg;

  localparam int WINDOW_DEPTH = 18;
  localparam int KW_COUNT     = 35;
  localparam int KW_MAX_LEN   = 19;
  localparam int LANG_COUNT   = 6;

  // keyword indexes
  localparam int K_DEF          = 0;
  localparam int K_PRINT_SP     = 1;
  localparam int K_PRINT_PAR    = 2;
  localparam int K_PRINT_COL    = 3;
  localparam int K_INC_IOSTREAM = 4;
  localparam int K_COUT         = 5;
  localparam int K_INT_MAIN     = 6;
  localparam int K_STRUCT       = 7;
  localparam int K_INC_STDIO    = 8;
  localparam int K_PRINTF       = 9;
  localparam int K_SCANF        = 10;
  localparam int K_PUBLIC_CLASS = 11;
  localparam int K_SYSOUT       = 12;
  localparam int K_STATIC_MAIN  = 13;
  localparam int K_HTML         = 14;
  localparam int K_BODY         = 15;
  localparam int K_DIV          = 16;
  localparam int K_TABLE        = 17;
  localparam int K_FUNCTION     = 18;
  localparam int K_CONSOLE      = 19;
  localparam int K_LET          = 20;
  localparam int K_CONST        = 21;
  localparam int K_VAR          = 22;
  localparam int K_FOR_SP       = 23;
  localparam int K_IN_RANGE     = 24;
  localparam int K_WHILE_SP     = 25;
  localparam int K_IF_SP        = 26;
  localparam int K_ELIF_SP      = 27;
  localparam int K_ELSE_COLON   = 28;
  localparam int K_FOR_PAR      = 29;
  localparam int K_WHILE_PAR    = 30;
  localparam int K_DO_BRACE     = 31;
  localparam int K_IF_PAR       = 32;
  localparam int K_ELSE_IF_PAR  = 33;
  localparam int K_ELSE_BRACE   = 34;

  // language bits of the detected set
  localparam int L_PYTHON = 0;
  localparam int L_CPP    = 1;
  localparam int L_C      = 2;
  localparam int L_JAVA   = 3;
  localparam int L_HTML   = 4;
  localparam int L_JS     = 5;

  // class codes
  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLS_MIXED   = 3'd7;

  typedef logic [KW_COUNT-1:0]   kw_vec_t;
  typedef logic [LANG_COUNT-1:0] lang_set_t;

  // window control from the top level
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  // keyword text, right aligned: last character in the low byte
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "def", "print ", "print(", "print:", "#include <iostream>", "cout",
    "int main", "struct", "#include <stdio.h>", "printf", "scanf",
    "public class", "System.out.println", "static void main", "<html>",
    "<body>", "<div>", "<table>", "function", "console.log", "let", "const",
    "var", "for ", "in range", "while ", "if ", "elif ", "else:", "for (",
    "while (", "do {", "if (", "else if (", "else {"
  };

  localparam int KW_LEN [KW_COUNT] = '{
    3, 6, 6, 6, 19, 4, 8, 6, 18, 6, 5, 12, 18, 16, 6, 6, 5, 7, 8, 11,
    3, 5, 3, 4, 8, 6, 3, 5, 5, 5, 7, 4, 4, 9, 6
  };

endpackage

// ===== hw/rtl/kwsig_matcher.sv =====
// byte window and parallel keyword comparators
module kwsig_matcher (
  input  logic                clk,
  input  logic                rst,
  input  kwsig_pkg::win_ctrl_t ctrl,
  input  logic [7:0]          text_byte,
  output kwsig_pkg::kw_vec_t  hit
);
  import kwsig_pkg::*;

  logic [7:0] window [WINDOW_DEPTH];

  // newest byte at index 0
  always_ff @(posedge clk) begin
    if (rst || (ctrl.shift && ctrl.clear)) begin
      for (int d = 0; d < WINDOW_DEPTH; d++) window[d] <= 8'h00;
    end else if (ctrl.shift) begin
      window[0] <= text_byte;
      for (int d = 1; d < WINDOW_DEPTH; d++) window[d] <= window[d-1];
    end
  end

  // keyword ends on the incoming byte
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = (KW_LEN[k] <= WINDOW_DEPTH + 1);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < KW_LEN[k]) begin
          if (i == 0) begin
            hit[k] = hit[k] && (KW_TEXT[k][8*i +: 8] == text_byte);
          end else begin
            hit[k] = hit[k] && (KW_TEXT[k][8*i +: 8] == window[i-1]);
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/kwsig_rules.sv =====
// language rules over the keyword bits and class encoding
module kwsig_rules (
  input  kwsig_pkg::kw_vec_t  seen,
  output kwsig_pkg::lang_set_t detected,
  output logic [2:0]          lang_class
);
  import kwsig_pkg::*;

  logic brace_cond;
  logic js_cond;
  logic java_mark;
  logic [2:0] n_set;
  logic [2:0] first_code;

  assign brace_cond = seen[K_FOR_PAR] | seen[K_WHILE_PAR] | seen[K_DO_BRACE] |
                      seen[K_IF_PAR] | seen[K_ELSE_IF_PAR] | seen[K_ELSE_BRACE];
  assign js_cond    = seen[K_FOR_PAR] | seen[K_WHILE_PAR] | seen[K_IF_PAR] |
                      seen[K_ELSE_IF_PAR] | seen[K_ELSE_BRACE];
  assign java_mark  = seen[K_PUBLIC_CLASS] | seen[K_SYSOUT] | seen[K_STATIC_MAIN];

  always_comb begin
    detected[L_PYTHON] = seen[K_DEF] | seen[K_PRINT_SP] | seen[K_PRINT_PAR] |
                         seen[K_PRINT_COL] | (seen[K_FOR_SP] & seen[K_IN_RANGE]) |
                         seen[K_WHILE_SP] | seen[K_IF_SP] | seen[K_ELIF_SP] |
                         seen[K_ELSE_COLON];
    detected[L_CPP]    = seen[K_INC_IOSTREAM] | seen[K_COUT] | seen[K_INT_MAIN] |
                         seen[K_STRUCT] | (brace_cond & seen[K_COUT]);
    detected[L_C]      = seen[K_INC_STDIO] & (seen[K_PRINTF] | seen[K_SCANF]);
    detected[L_JAVA]   = java_mark | (brace_cond & java_mark);
    detected[L_HTML]   = seen[K_HTML] | seen[K_BODY] | seen[K_DIV] | seen[K_TABLE];
    detected[L_JS]     = seen[K_FUNCTION] | seen[K_CONSOLE] | seen[K_LET] |
                         seen[K_CONST] | seen[K_VAR] | (js_cond & seen[K_CONSOLE]);
  end

  // lowest set language gives the single-language code
  always_comb begin
    n_set      = 3'd0;
    first_code = CLS_UNKNOWN;
    for (int l = LANG_COUNT - 1; l >= 0; l--) begin
      if (detected[l]) begin
        first_code = 3'(l + 1);
      end
    end
    for (int l = 0; l < LANG_COUNT; l++) begin
      n_set = n_set + 3'(detected[l]);
    end
  end

  always_comb begin
    unique if (n_set == 3'd0) begin
      lang_class = CLS_UNKNOWN;
    end else if (n_set == 3'd1) begin
      lang_class = first_code;
    end else begin
      lang_class = CLS_MIXED;
    end
  end

endmodule

// ===== hw/rtl/keyword_signature_language_classifier.sv =====
// top level: keyword signature language classifier with registered result word
// latency: a result word appears in the cycle after its final byte is accepted
// throughput: one byte per cycle; all comparators check the window in parallel
// the only stall is a result word held by a low out_ready
// reset (rst, synchronous): byte window zeroed, keyword bits cleared, no result word
// the window and keyword bits also clear after every final byte
module keyword_signature_language_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] language_class,
  output logic [5:0] detected_set
);
  import kwsig_pkg::*;

  logic       accept;
  win_ctrl_t  win_ctrl;
  kw_vec_t    hit;
  kw_vec_t    seen;
  kw_vec_t    seen_next;
  kw_vec_t    seen_now;
  lang_set_t  rule_set;
  logic [2:0] rule_class;
  logic       out_valid_next;

  // the result register frees as soon as its word is taken
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign win_ctrl.shift = accept;
  assign win_ctrl.clear = last_byte;

  kwsig_matcher u_matcher (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (win_ctrl),
    .text_byte (text_byte),
    .hit       (hit)
  );

  // the final byte takes part in matching before the rules run
  assign seen_now = seen | hit;

  kwsig_rules u_rules (
    .seen       (seen_now),
    .detected   (rule_set),
    .lang_class (rule_class)
  );

  // sticky keyword bits, cleared once a text ends
  always_comb begin
    seen_next = seen;
    if (accept) begin
      seen_next = last_byte ? '0 : seen_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else begin
      seen <= seen_next;
    end
  end

  // result word register
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (accept && last_byte) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      language_class <= rule_class;
      detected_set   <= rule_set;
    end
  end

`ifndef SYNTHESIS
  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> out_valid)
    else $error("no result word after final byte");

  a_bits_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> seen == '0)
    else $error("keyword bits not cleared after final byte");

  a_stall_only_on_held_word: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result word");

  a_empty_set_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && detected_set == '0 |-> language_class == CLS_UNKNOWN)
    else $error("empty set not classed unknown");

  a_many_set_mixed: assert property (@(posedge clk) disable iff (rst)
    out_valid && $countones(detected_set) > 1 |-> language_class == CLS_MIXED)
    else $error("several languages not classed mixed");
`endif

endmodule
